[rtl/adt_pkg.sv]
// ----------------------------------------------------------------------------
// adt_pkg: shared types and constants of the alert dedup table
// function codes, register indexes, score constants and the one risk helper of its functions
// ----------------------------------------------------------------------------
package adt_pkg;

    // width of every time field, fixed by the stream layout
    localparam int TIME_BITS = 40;

    localparam logic [1:0] FUNC_INGEST = 2'd0;
    localparam logic [1:0] FUNC_EXPIRE = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    localparam logic [1:0] REG_SUPPRESS = 2'd0;
    localparam logic [1:0] REG_DEDUP    = 2'd1;
    localparam logic [1:0] REG_MAX      = 2'd2;

    localparam logic [6:0] CONF_SIG   = 7'd90;
    localparam logic [6:0] CONF_PLAIN = 7'd70;
    localparam logic [6:0] RISK_CAP   = 7'd100;
    localparam logic [2:0] SEV_MAX    = 3'd4;
    localparam logic [2:0] SEV_DEF    = 3'd2;

    // risk from severity and signature flag
    function automatic logic [6:0] risk_of(input logic [2:0] sev, input logic sig);
        logic [7:0] r;
        r = {5'd0, sev} * 8'd20 + {1'b0, (sig ? CONF_SIG : CONF_PLAIN) >> 1};
        return (r > {1'b0, RISK_CAP}) ? RISK_CAP : r[6:0];
    endfunction

endpackage

[rtl/alert_dedup_table.sv]
// ----------------------------------------------------------------------------
// alert_dedup_table: alert deduplication table
// keyed alert store with repeat suppression, eviction and expiry sweeps
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one request per item: ingest, expire sweep or clear.
//   an ingest of a known key bumps its count and either suppresses the
//   alert or re-emits it on m_axis; a new key is inserted and emitted.
//   cfg writes set the suppress window, dedup window and entry limit; they
//   must only be made while the block is idle, which the block does not enforce.
// timing
//   an ingest scans every slot once through a single entry memory port,
//   one slot per cycle through the registered read, then decides, reads
//   and writes the slot: a suppressed repeat is finished by the write; an
//   emitted alert reads the slot back and loads the output register when
//   the register is free, which raises m_tvalid. a sweep reads and then
//   judges each slot in turn; a clear or an unknown function is finished
//   as it is accepted. s_tready is low from acceptance until the item is
//   finished.
// reset and stall
//   aresetn clears valid bits, counters and control and presets the id and cfg
//   registers; the entry memory needs no clearing pass. a result waits in
//   the output register while m_tready is low; the next request may still be
//   taken and processed, but its own result then waits until the register frees.
// ----------------------------------------------------------------------------
module alert_dedup_table
    import adt_pkg::*;
#(
    parameter int CAPACITY  = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // func[1:0], key[65:2], timestamp[105:66], is_signature[106],
    // rule_severity[109:107], zero fill to 112
    input  logic [111:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // alert_id[31:0], is_repeat[32], sighting count[64:33],
    // window start[104:65], latest sighting[144:105], severity[147:145],
    // confidence[154:148], risk[161:155], total_suppressed[225:162],
    // total_emitted[289:226], zero fill to 296
    output logic [295:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = AW + 1;
    localparam int TW = TIME_BITS;
    // entry record width: key, first, last, count, id, sev, sig
    localparam int EW = 64 + TW + TW + 32 + 32 + 3 + 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_DEC   = 3'd2;
    localparam logic [2:0] ST_RD    = 3'd3;
    localparam logic [2:0] ST_UPD   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;
    localparam logic [2:0] ST_SWEEP = 3'd6;
    localparam logic [2:0] ST_WB    = 3'd7;

    logic [2:0] state_reg, state_next;

    logic [31:0] supp_win_reg, dedup_win_reg;
    logic [6:0]  max_reg;
    logic [CAPACITY-1:0] valid_reg;
    logic [31:0] next_id_reg;
    logic [63:0] supp_tot_reg, emit_tot_reg;

    // request latch
    logic [63:0]   key_reg;
    logic [TW-1:0] ts_reg;
    logic          sig_reg;
    logic [2:0]    sev_reg;

    // scan bookkeeping
    logic [CW-1:0] cnt_reg;     // address issued
    logic          rv_reg;      // read data valid this cycle
    logic [AW-1:0] raddr_reg;   // slot of read data
    logic          hit_reg;
    logic [AW-1:0] hit_slot_reg;
    logic          old_reg;
    logic [AW-1:0] old_slot_reg;
    logic [TW-1:0] old_last_reg;
    logic [CW-1:0] used_reg;
    logic          free_reg;
    logic [AW-1:0] free_slot_reg;
    logic [AW-1:0] slot_reg;
    logic          is_new_reg;

    // memory port
    logic          we;
    logic [AW-1:0] addr;
    logic [EW-1:0] wdata, rdata;

    adt_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
        .aclk (aclk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    logic [63:0]   r_key;
    logic [TW-1:0] r_first, r_last;
    logic [31:0]   r_count, r_id;
    logic [2:0]    r_sev;
    logic          r_sig;
    assign {r_key, r_first, r_last, r_count, r_id, r_sev, r_sig} = rdata;

    // output register
    logic         ovalid_reg;
    logic [295:0] odata_reg;

    assign m_tvalid  = ovalid_reg;
    assign m_tdata   = odata_reg;
    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);

    wire s_acc = s_tvalid && s_tready;
    wire scan_done = (cnt_reg == CW'(CAPACITY));

    // shared compare unit: signed time difference against a window
    logic [TW:0]   diff;
    logic [TW-1:0] cmp_a, cmp_b;
    logic [31:0]   cmp_win;
    logic          diff_le;
    always_comb begin
        diff = {1'b0, cmp_a} - {1'b0, cmp_b};
        // diff_le: a - b <= win (signed diff)
        diff_le = diff[TW] || (diff[TW-1:0] <= TW'(cmp_win));
    end

    // effective limit
    logic [CW-1:0] limit;
    always_comb begin
        if (max_reg == 7'd0) limit = CW'(1);
        else if ({25'd0, max_reg} > CAPACITY) limit = CW'(CAPACITY);
        else limit = CW'(max_reg);
    end

    // sweep phase: splits each slot into a read step and a judge step
    logic sweep_wr_reg;

    logic [31:0] new_count;
    assign new_count = (r_count == 32'hFFFF_FFFF) ? r_count : r_count + 32'd1;

    logic [2:0] sev_clamp;
    assign sev_clamp = (sev_reg > SEV_MAX) ? SEV_DEF : sev_reg;

    // the output register takes a result when it is empty or being drained
    wire out_load = (state_reg == ST_OUT) && (!ovalid_reg || m_tready);

    always_comb begin
        we      = 1'b0;
        addr    = cnt_reg[AW-1:0];
        wdata   = rdata;
        cmp_a   = ts_reg;
        cmp_b   = r_last;
        cmp_win = dedup_win_reg;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    unique case (s_tdata[1:0])
                        FUNC_INGEST: state_next = ST_SCAN;
                        FUNC_EXPIRE: state_next = ST_SWEEP;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN: begin
                if (scan_done && !rv_reg) state_next = ST_DEC;
            end
            ST_DEC: begin
                state_next = ST_RD;
            end
            ST_RD: begin
                addr = slot_reg;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                addr = slot_reg;
                we   = 1'b1;
                if (is_new_reg) begin
                    wdata = {key_reg, ts_reg, ts_reg, 32'd1, next_id_reg,
                             sev_clamp, sig_reg};
                    state_next = ST_WB;
                end else begin
                    cmp_b   = r_first;
                    cmp_win = supp_win_reg;
                    wdata = {r_key, (diff_le ? r_first : ts_reg), ts_reg, new_count,
                             r_id, r_sev, r_sig};
                    state_next = diff_le ? ST_IDLE : ST_WB;
                end
            end
            ST_WB: begin
                // read the updated entry back for the result
                addr = slot_reg;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                addr = slot_reg;
                if (!ovalid_reg || m_tready) state_next = ST_IDLE;
            end
            ST_SWEEP: begin
                if (scan_done && !sweep_wr_reg) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // expiry decision uses the same compare unit during sweep reads
    wire expired = !diff_le;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            supp_win_reg  <= 32'd60;
            dedup_win_reg <= 32'd300;
            max_reg       <= 7'd64;
            valid_reg     <= '0;
            next_id_reg   <= 32'd1;
            supp_tot_reg  <= '0;
            emit_tot_reg  <= '0;
            ovalid_reg    <= 1'b0;
            cnt_reg       <= '0;
            rv_reg        <= 1'b0;
            sweep_wr_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_SUPPRESS: supp_win_reg  <= cfg_data;
                    REG_DEDUP:    dedup_win_reg <= cfg_data;
                    REG_MAX:      max_reg       <= cfg_data[6:0];
                    default: ;
                endcase
            end
            if (out_load) ovalid_reg <= 1'b1;
            else if (m_tready) ovalid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    cnt_reg      <= '0;
                    rv_reg       <= 1'b0;
                    sweep_wr_reg <= 1'b0;
                    if (s_acc && s_tdata[1:0] == FUNC_CLEAR) valid_reg <= '0;
                end
                ST_SCAN: begin
                    rv_reg <= !scan_done;
                    if (!scan_done) cnt_reg <= cnt_reg + CW'(1);
                end
                ST_UPD: begin
                    if (is_new_reg) begin
                        valid_reg[slot_reg] <= 1'b1;
                        next_id_reg  <= next_id_reg + 32'd1;
                        emit_tot_reg <= emit_tot_reg + 64'd1;
                    end else if (diff_le) begin
                        supp_tot_reg <= supp_tot_reg + 64'd1;
                    end else begin
                        emit_tot_reg <= emit_tot_reg + 64'd1;
                    end
                end
                ST_SWEEP: begin
                    // even cycle issues a read, odd cycle judges the data
                    sweep_wr_reg <= !sweep_wr_reg && !scan_done;
                    if (sweep_wr_reg) begin
                        if (valid_reg[cnt_reg[AW-1:0]] && expired)
                            valid_reg[cnt_reg[AW-1:0]] <= 1'b0;
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                default: ;
            endcase
            if (state_reg == ST_DEC && !hit_reg && used_reg >= limit && old_reg)
                valid_reg[old_slot_reg] <= 1'b0;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge aclk) begin
        raddr_reg <= cnt_reg[AW-1:0];
        unique case (state_reg)
            ST_IDLE: begin
                key_reg  <= s_tdata[65:2];
                ts_reg   <= s_tdata[66 +: TW];
                sig_reg  <= s_tdata[106];
                sev_reg  <= s_tdata[109:107];
                hit_reg  <= 1'b0;
                old_reg  <= 1'b0;
                free_reg <= 1'b0;
                used_reg <= '0;
            end
            ST_SCAN: begin
                if (rv_reg && valid_reg[raddr_reg]) begin
                    used_reg <= used_reg + CW'(1);
                    if (!hit_reg && r_key == key_reg) begin
                        hit_reg      <= 1'b1;
                        hit_slot_reg <= raddr_reg;
                    end
                    if (!old_reg || r_last < old_last_reg) begin
                        old_reg      <= 1'b1;
                        old_slot_reg <= raddr_reg;
                        old_last_reg <= r_last;
                    end
                end else if (rv_reg && !free_reg) begin
                    free_reg      <= 1'b1;
                    free_slot_reg <= raddr_reg;
                end
            end
            ST_DEC: begin
                is_new_reg <= !hit_reg;
                if (hit_reg) slot_reg <= hit_slot_reg;
                else if (used_reg >= limit && old_reg &&
                         (!free_reg || old_slot_reg < free_slot_reg))
                    slot_reg <= old_slot_reg;
                else slot_reg <= free_slot_reg;
            end
            ST_OUT: begin
                if (!ovalid_reg || m_tready) begin
                    odata_reg <= {6'd0, emit_tot_reg, supp_tot_reg,
                                  risk_of(r_sev, r_sig),
                                  (r_sig ? CONF_SIG : CONF_PLAIN), r_sev,
                                  r_last, r_first, r_count,
                                  !is_new_reg, r_id};
                end
            end
            default: ;
        endcase
    end
endmodule

[rtl/adt_ram.sv]
// ----------------------------------------------------------------------------
// adt_ram: generic single-port ram
// one address per cycle, read every cycle (old contents while writing), registered read data
// ----------------------------------------------------------------------------
module adt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
